FILE: rtl/aor_pkg.sv
// ----------------------------------------------------------------------------
// aor_pkg
// Shared widths, flag bit positions, word and stage types, and the strict
// box overlap test used on entry and after resolution.
// ----------------------------------------------------------------------------
`default_nettype none

package aor_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
    localparam int FLAG_WIDTH  = 4;

    // constraint flag bit positions
    localparam int FL_STATIC = 0;
    localparam int FL_NOH    = 1;
    localparam int FL_NOV    = 2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic        [SIZE_WIDTH-1:0]  t_size;
    typedef logic        [FLAG_WIDTH-1:0]  t_flags;

    typedef enum logic [1:0] {
        AXIS_NONE,
        AXIS_X,
        AXIS_Y
    } t_axis;

    typedef struct packed {
        t_coord a_x;
        t_coord a_y;
        t_size  a_w;
        t_size  a_h;
        t_coord b_x;
        t_coord b_y;
        t_size  b_w;
        t_size  b_h;
        t_flags a_flags;
        t_flags b_flags;
    } t_in_word;

    typedef struct packed {
        t_coord new_a_x;
        t_coord new_a_y;
        t_coord new_b_x;
        t_coord new_b_y;
        logic   overlapped_before;
        logic   still_overlapping;
    } t_out_word;

    // after detection: overlaps seen from A and from B differ only on a tie
    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_size  aw;
        t_size  ah;
        t_coord bx;
        t_coord by;
        t_size  bw;
        t_size  bh;
        t_flags af;
        t_flags bf;
        logic   ovl_in;
        logic   move;
        logic   gtx;
        logic   ltx;
        logic   gty;
        logic   lty;
        t_size  ox_a;
        t_size  oy_a;
        t_size  ox_b;
        t_size  oy_b;
    } t_det;

    // after resolution: wrapped positions, sizes for the final test
    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_size  aw;
        t_size  ah;
        t_coord bx;
        t_coord by;
        t_size  bw;
        t_size  bh;
        logic   ovl_in;
    } t_res;

    typedef logic signed [COORD_WIDTH:0] t_wide;

    function automatic t_wide widen_size(input t_size s);
        return $signed({2'b00, s});
    endfunction

    // strict interior intersection on both axes, sums one bit wider
    function automatic logic boxes_overlap(
        input t_coord ax, input t_coord ay, input t_size aw, input t_size ah,
        input t_coord bx, input t_coord by, input t_size bw, input t_size bh
    );
        t_wide ax_e;
        t_wide ay_e;
        t_wide bx_e;
        t_wide by_e;
        ax_e = ax;
        ay_e = ay;
        bx_e = bx;
        by_e = by;
        return (ax_e < bx_e + widen_size(bw)) && (ax_e + widen_size(aw) > bx_e) &&
               (ay_e < by_e + widen_size(bh)) && (ay_e + widen_size(ah) > by_e);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/aabb_overlap_resolver_top.sv
// ----------------------------------------------------------------------------
// aabb_overlap_resolver_top
// Resolves the overlap of one pair of axis-aligned boxes per word.
//
//   channel   direction  handshake                    word
//   input     in         i_in_valid / o_in_ready      i_in_data  (t_in_word)
//   output    out        o_out_valid / i_out_ready    o_out_data (t_out_word)
//
// one word per cycle sustained while i_out_ready is high; a result passes
// the input register, detect, resolve and the overlap recheck into the output
// register. each stage holds one word and moves on when the next stage is
// empty or moving, so input is taken while a result waits until all four
// stages hold a word. synchronous active-low reset empties all stages.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_overlap_resolver_top
    import aor_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  wire       i_out_ready,
    output t_out_word o_out_data
);

    logic      r_v0;
    logic      r_v1;
    logic      r_v2;
    logic      r_v3;
    t_in_word  r_in;
    t_det      r_s1;
    t_res      r_s2;
    t_out_word r_out;

    t_det      n_s1;
    t_res      n_s2;
    t_out_word n_out;

    logic en0;
    logic en1;
    logic en2;
    logic en3;

    always_comb begin
        en3 = !r_v3 || i_out_ready;
        en2 = !r_v2 || en3;
        en1 = !r_v1 || en2;
        en0 = !r_v0 || en1;
    end

    assign o_in_ready  = en0;
    assign o_out_valid = r_v3;
    assign o_out_data  = r_out;

    aor_detect u_detect (
        .i_word (r_in),
        .o_det  (n_s1)
    );

    aor_resolve u_resolve (
        .i_det (r_s1),
        .o_res (n_s2)
    );

    aor_check u_check (
        .i_res  (r_s2),
        .o_word (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en0) begin
                r_v0 <= i_in_valid;
            end
            if (en1) begin
                r_v1 <= r_v0;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_in <= i_in_data;
        end
        if (en1) begin
            r_s1 <= n_s1;
        end
        if (en2) begin
            r_s2 <= n_s2;
        end
        if (en3) begin
            r_out <= n_out;
        end
    end

    // an empty output stage never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v3 |-> o_in_ready)
        else $error("input stalled with empty output stage");

    // boxes apart on entry never move, so they cannot overlap afterwards
    a_no_new_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_out.overlapped_before) |-> !r_out.still_overlapping)
        else $error("overlap created from separated boxes");

    // a word needing no move passes its positions through the resolve stage
    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && en2 && !r_s1.move) |=>
        (r_s2.ax == $past(r_s1.ax) && r_s2.ay == $past(r_s1.ay) &&
         r_s2.bx == $past(r_s1.bx) && r_s2.by == $past(r_s1.by)))
        else $error("positions changed without a move");

endmodule

`default_nettype wire

FILE: rtl/aor_detect.sv
// ----------------------------------------------------------------------------
// aor_detect
// Entry overlap test, identity check, position order and per-axis overlap
// depths seen from each box.
// ----------------------------------------------------------------------------
`default_nettype none

module aor_detect
    import aor_pkg::*;
(
    input  t_in_word i_word,
    output t_det     o_det
);

    t_wide ax_e;
    t_wide ay_e;
    t_wide bx_e;
    t_wide by_e;
    t_wide dx_ba;
    t_wide dx_ab;
    t_wide dy_ba;
    t_wide dy_ab;
    logic  ovl_in;
    logic  same_box;

    always_comb begin
        ax_e = i_word.a_x;
        ay_e = i_word.a_y;
        bx_e = i_word.b_x;
        by_e = i_word.b_y;

        // depths are below 2^31 whenever the boxes overlap, low bits suffice
        dx_ba = bx_e + widen_size(i_word.b_w) - ax_e;
        dx_ab = ax_e + widen_size(i_word.a_w) - bx_e;
        dy_ba = by_e + widen_size(i_word.b_h) - ay_e;
        dy_ab = ay_e + widen_size(i_word.a_h) - by_e;

        ovl_in = boxes_overlap(i_word.a_x, i_word.a_y, i_word.a_w, i_word.a_h,
                               i_word.b_x, i_word.b_y, i_word.b_w, i_word.b_h);
        same_box = (i_word.a_x == i_word.b_x) && (i_word.a_y == i_word.b_y) &&
                   (i_word.a_w == i_word.b_w) && (i_word.a_h == i_word.b_h);

        o_det.ax     = i_word.a_x;
        o_det.ay     = i_word.a_y;
        o_det.aw     = i_word.a_w;
        o_det.ah     = i_word.a_h;
        o_det.bx     = i_word.b_x;
        o_det.by     = i_word.b_y;
        o_det.bw     = i_word.b_w;
        o_det.bh     = i_word.b_h;
        o_det.af     = i_word.a_flags;
        o_det.bf     = i_word.b_flags;
        o_det.ovl_in = ovl_in;
        o_det.move   = ovl_in && !same_box;
        o_det.gtx    = i_word.a_x > i_word.b_x;
        o_det.ltx    = i_word.a_x < i_word.b_x;
        o_det.gty    = i_word.a_y > i_word.b_y;
        o_det.lty    = i_word.a_y < i_word.b_y;

        // a tie on position takes the reference box's own size
        o_det.ox_a = o_det.gtx ? dx_ba[SIZE_WIDTH-1:0] :
                     o_det.ltx ? dx_ab[SIZE_WIDTH-1:0] : i_word.a_w;
        o_det.ox_b = o_det.gtx ? dx_ba[SIZE_WIDTH-1:0] :
                     o_det.ltx ? dx_ab[SIZE_WIDTH-1:0] : i_word.b_w;
        o_det.oy_a = o_det.gty ? dy_ba[SIZE_WIDTH-1:0] :
                     o_det.lty ? dy_ab[SIZE_WIDTH-1:0] : i_word.a_h;
        o_det.oy_b = o_det.gty ? dy_ba[SIZE_WIDTH-1:0] :
                     o_det.lty ? dy_ab[SIZE_WIDTH-1:0] : i_word.b_h;
    end

endmodule

`default_nettype wire

FILE: rtl/aor_resolve.sv
// ----------------------------------------------------------------------------
// aor_resolve
// Picks the resolution case from the flags and applies the position moves,
// wrapping to the coordinate width.
// ----------------------------------------------------------------------------
`default_nettype none

module aor_resolve
    import aor_pkg::*;
(
    input  t_det i_det,
    output t_res o_res
);

    function automatic t_coord to_delta(input t_size mag, input logic neg);
        t_coord m;
        m = $signed({1'b0, mag});
        return neg ? -m : m;
    endfunction

    // axis along which a box pushed by a static partner moves
    function automatic t_axis push_axis(input t_flags f, input t_size ox, input t_size oy);
        if (f == '0) begin
            return (ox < oy) ? AXIS_X : AXIS_Y;
        end else if (f[FL_NOH]) begin
            return AXIS_Y;
        end else if (f[FL_NOV]) begin
            return AXIS_X;
        end
        return AXIS_NONE;
    endfunction

    t_coord d_ax;
    t_coord d_ay;
    t_coord d_bx;
    t_coord d_by;
    t_size  hx_a;
    t_size  hy_a;
    t_size  hx_b;
    t_size  hy_b;
    t_axis  a_push;
    t_axis  b_push;

    always_comb begin
        d_ax   = '0;
        d_ay   = '0;
        d_bx   = '0;
        d_by   = '0;
        hx_a   = i_det.ox_a >> 1;
        hy_a   = i_det.oy_a >> 1;
        hx_b   = i_det.ox_b >> 1;
        hy_b   = i_det.oy_b >> 1;
        b_push = push_axis(i_det.bf, i_det.ox_a, i_det.oy_a);
        a_push = push_axis(i_det.af, i_det.ox_b, i_det.oy_b);

        if (i_det.move) begin
            priority if (i_det.af[FL_STATIC]) begin
                if (!i_det.bf[FL_STATIC]) begin
                    unique case (b_push)
                        AXIS_X:    d_bx = to_delta(i_det.ox_a, !i_det.ltx);
                        AXIS_Y:    d_by = to_delta(i_det.oy_a, !i_det.lty);
                        AXIS_NONE: ;
                    endcase
                end
            end else if (i_det.bf[FL_STATIC]) begin
                unique case (a_push)
                    AXIS_X:    d_ax = to_delta(i_det.ox_b, !i_det.gtx);
                    AXIS_Y:    d_ay = to_delta(i_det.oy_b, !i_det.gty);
                    AXIS_NONE: ;
                endcase
            end else if (i_det.af == '0) begin
                // A free: shares the depth when B may move on that axis
                if (i_det.ox_a < i_det.oy_a) begin
                    if (!i_det.bf[FL_NOH]) begin
                        if (i_det.gtx || i_det.ltx) begin
                            d_ax = to_delta(hx_a, i_det.ltx);
                            d_bx = to_delta(hx_a, i_det.gtx);
                        end
                    end else begin
                        d_ax = to_delta(i_det.ox_a, i_det.ltx);
                    end
                end else begin
                    if (!i_det.bf[FL_NOV]) begin
                        if (i_det.gty || i_det.lty) begin
                            d_ay = to_delta(hy_a, i_det.lty);
                            d_by = to_delta(hy_a, i_det.gty);
                        end
                    end else begin
                        d_ay = to_delta(i_det.oy_a, i_det.lty);
                    end
                end
            end else if (i_det.bf == '0) begin
                // B free, same with roles swapped
                if (i_det.ox_b < i_det.oy_b) begin
                    if (!i_det.af[FL_NOH]) begin
                        if (i_det.gtx || i_det.ltx) begin
                            d_bx = to_delta(hx_b, i_det.gtx);
                            d_ax = to_delta(hx_b, i_det.ltx);
                        end
                    end else begin
                        d_bx = to_delta(i_det.ox_b, i_det.gtx);
                    end
                end else begin
                    if (!i_det.af[FL_NOV]) begin
                        if (i_det.gty || i_det.lty) begin
                            d_by = to_delta(hy_b, i_det.gty);
                            d_ay = to_delta(hy_b, i_det.lty);
                        end
                    end else begin
                        d_by = to_delta(i_det.oy_b, i_det.gty);
                    end
                end
            end else begin
                // A slides along x if NOV is set, else along y if NOH is set
                if (i_det.af[FL_NOV]) begin
                    d_ax = to_delta(i_det.ox_a, i_det.ltx);
                end else if (i_det.af[FL_NOH]) begin
                    d_ay = to_delta(i_det.oy_a, i_det.lty);
                end
            end
        end

        o_res.ax     = i_det.ax + d_ax;
        o_res.ay     = i_det.ay + d_ay;
        o_res.bx     = i_det.bx + d_bx;
        o_res.by     = i_det.by + d_by;
        o_res.aw     = i_det.aw;
        o_res.ah     = i_det.ah;
        o_res.bw     = i_det.bw;
        o_res.bh     = i_det.bh;
        o_res.ovl_in = i_det.ovl_in;
    end

endmodule

`default_nettype wire

FILE: rtl/aor_check.sv
// ----------------------------------------------------------------------------
// aor_check
// Overlap test on the resolved positions and packing of the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module aor_check
    import aor_pkg::*;
(
    input  t_res      i_res,
    output t_out_word o_word
);

    always_comb begin
        o_word.new_a_x           = i_res.ax;
        o_word.new_a_y           = i_res.ay;
        o_word.new_b_x           = i_res.bx;
        o_word.new_b_y           = i_res.by;
        o_word.overlapped_before = i_res.ovl_in;
        o_word.still_overlapping = boxes_overlap(i_res.ax, i_res.ay, i_res.aw, i_res.ah,
                                                 i_res.bx, i_res.by, i_res.bw, i_res.bh);
    end

endmodule

`default_nettype wire
